// ===== rtl/mat4_inverse_adjugate_macros.svh =====
// Assertion macros for the 4x4 matrix inverse block.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef MAT4_INVERSE_ADJUGATE_MACROS_SVH
`define MAT4_INVERSE_ADJUGATE_MACROS_SVH

// same-cycle implication
`define M4INV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m4inv: same-cycle check failed");

// next-cycle implication
`define M4INV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m4inv: next-cycle check failed");

`endif

// ===== rtl/m4inv_pkg.sv =====
// Shared types, constants and decode functions for the 4x4 matrix inverse block.
// No dependencies.
package m4inv_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int WIDE_W  = 64;
  localparam int NELEM   = 16;
  localparam int IDX_W   = 4;
  localparam int MREG_N  = 10;
  localparam int CFG_W   = 32;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] DATA_MAX =
    (WIDE_W'(1) <<< (DATA_W-1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] DATA_MIN = -DATA_MAX - WIDE_W'(1);

  localparam logic [1:0] MODE_INV = 2'd0;
  localparam logic [1:0] MODE_ADJ = 2'd1;
  localparam logic [1:0] MODE_COF = 2'd2;

  localparam logic REG_MODE = 1'b0;

  localparam logic [IDX_W-1:0] LAST_IDX  = 4'd15;
  localparam logic [3:0]       UOP_COF   = 4'd8;
  localparam logic [3:0]       UOP_DET   = 4'd9;
  localparam logic [3:0]       MINOR_END = 4'd10;
  localparam logic [3:0]       E0_SLOT   = 4'd9;

  typedef enum logic [1:0] {AOP_CLR, AOP_ADD, AOP_SUB} aop_t;
  typedef enum logic [2:0] {Y_M6, Y_M7, Y_M8, Y_T0, Y_T1, Y_T2, Y_COF} ysel_t;
  typedef enum logic [2:0] {D_ACC, D_T0, D_T1, D_T2, D_COF, D_DET} dest_t;
  typedef enum logic [1:0] {SRC_MAT, SRC_COF, SRC_DIV} src_t;

  typedef struct packed {
    logic [3:0] xsel;
    ysel_t      ysel;
    aop_t       aop;
    dest_t      dest;
  } uop_t;

  typedef struct packed {
    logic             mat_we;
    logic [IDX_W-1:0] mat_waddr;
    logic [IDX_W-1:0] mat_raddr;
    logic             ld_en;
    logic [3:0]       ld_idx;
    logic             ov_clr;
    logic             run_clr;
    logic             mul_start;
    logic             apply;
    uop_t             uop;
    logic             neg;
    logic             cof_we;
    logic [IDX_W-1:0] cof_waddr;
    logic [IDX_W-1:0] cof_raddr;
    logic             fin;
    logic             div_start;
    logic             out_load;
    src_t             out_src;
    logic [IDX_W-1:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sing;
  } status_t;

  // 3x3 determinant as a multiply-accumulate sequence over the minor m0..m8,
  // then one determinant term e0 * cofactor
  function automatic uop_t uop_dec(input logic [3:0] u);
    uop_t d;
    d = '{xsel: 4'd0, ysel: Y_M8, aop: AOP_CLR, dest: D_ACC};
    unique case (u)
      4'd0:    d = '{xsel: 4'd4, ysel: Y_M8,  aop: AOP_CLR, dest: D_ACC};
      4'd1:    d = '{xsel: 4'd5, ysel: Y_M7,  aop: AOP_SUB, dest: D_T0};
      4'd2:    d = '{xsel: 4'd3, ysel: Y_M8,  aop: AOP_CLR, dest: D_ACC};
      4'd3:    d = '{xsel: 4'd5, ysel: Y_M6,  aop: AOP_SUB, dest: D_T1};
      4'd4:    d = '{xsel: 4'd3, ysel: Y_M7,  aop: AOP_CLR, dest: D_ACC};
      4'd5:    d = '{xsel: 4'd4, ysel: Y_M6,  aop: AOP_SUB, dest: D_T2};
      4'd6:    d = '{xsel: 4'd0, ysel: Y_T0,  aop: AOP_CLR, dest: D_ACC};
      4'd7:    d = '{xsel: 4'd1, ysel: Y_T1,  aop: AOP_SUB, dest: D_ACC};
      4'd8:    d = '{xsel: 4'd2, ysel: Y_T2,  aop: AOP_ADD, dest: D_COF};
      4'd9:    d = '{xsel: 4'd9, ysel: Y_COF, aop: AOP_ADD, dest: D_DET};
      default: d = '{xsel: 4'd0, ysel: Y_M8,  aop: AOP_CLR, dest: D_ACC};
    endcase
    return d;
  endfunction

  // store address of minor element k (row-major) for cofactor (r, c); k = 9 gives (0, c)
  function automatic logic [IDX_W-1:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                                   input logic [3:0] k);
    logic [1:0] ki;
    logic [1:0] kj;
    logic [1:0] row;
    logic [1:0] col;
    ki = 2'd0;
    kj = 2'd0;
    unique case (k)
      4'd0:    begin ki = 2'd0; kj = 2'd0; end
      4'd1:    begin ki = 2'd0; kj = 2'd1; end
      4'd2:    begin ki = 2'd0; kj = 2'd2; end
      4'd3:    begin ki = 2'd1; kj = 2'd0; end
      4'd4:    begin ki = 2'd1; kj = 2'd1; end
      4'd5:    begin ki = 2'd1; kj = 2'd2; end
      4'd6:    begin ki = 2'd2; kj = 2'd0; end
      4'd7:    begin ki = 2'd2; kj = 2'd1; end
      4'd8:    begin ki = 2'd2; kj = 2'd2; end
      default: begin ki = 2'd0; kj = 2'd0; end
    endcase
    row = ki + {1'b0, (ki >= r)};
    col = kj + {1'b0, (kj >= c)};
    if (k == E0_SLOT) return {c, 2'b00};
    return {col, row};
  endfunction

  // clamp to the data range; msb of the result is the saturation flag
  function automatic logic [DATA_W:0] sat_data(input logic signed [WIDE_W-1:0] v);
    if (v > DATA_MAX) return {1'b1, DATA_MAX[DATA_W-1:0]};
    if (v < DATA_MIN) return {1'b1, DATA_MIN[DATA_W-1:0]};
    return {1'b0, v[DATA_W-1:0]};
  endfunction

endpackage

// ===== rtl/m4inv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/m4inv_mul.sv =====
// Sequential 64x64 fixed-point multiplier: four 32x32 partial products,
// round half away from zero, symmetric saturation. Depends on m4inv_pkg.
module m4inv_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [m4inv_pkg::WIDE_W-1:0]   a,
  input  logic signed [m4inv_pkg::WIDE_W-1:0]   b,
  output logic                                  done,
  output logic signed [m4inv_pkg::WIDE_W-1:0]   res,
  output logic                                  ov
);

  localparam int W  = m4inv_pkg::WIDE_W;
  localparam int HW = W / 2;
  localparam int PW = 2 * W;

  typedef enum logic [1:0] {M_IDLE, M_PROD, M_LAST, M_RND} mstate_t;

  mstate_t         state;
  logic [1:0]      cnt;
  logic [1:0]      psh;
  logic [W-1:0]    ua;
  logic [W-1:0]    ub;
  logic            neg;
  logic [W-1:0]    prod;
  logic [PW-1:0]   acc;
  logic [PW-1:0]   acc_sum;
  logic [PW-1:0]   full;
  logic [PW-1:0]   q;
  logic            big;
  logic [W-1:0]    mag_r;
  logic [HW-1:0]   ah;
  logic [HW-1:0]   bh;

  always_comb begin
    ah = cnt[1] ? ua[W-1:HW] : ua[HW-1:0];
    bh = cnt[0] ? ub[W-1:HW] : ub[HW-1:0];
    unique case (psh)
      2'd0:    acc_sum = acc + {{W{1'b0}}, prod};
      2'd3:    acc_sum = acc + {prod, {W{1'b0}}};
      default: acc_sum = acc + ({{W{1'b0}}, prod} << HW);
    endcase
    full  = acc + (PW'(1) << (m4inv_pkg::FRAC_W - 1));
    q     = full >> m4inv_pkg::FRAC_W;
    big   = |q[PW-1:W-1];
    mag_r = big ? m4inv_pkg::WIDE_MAX : q[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            ua    <= a[W-1] ? (~a + W'(1)) : a;
            ub    <= b[W-1] ? (~b + W'(1)) : b;
            neg   <= a[W-1] ^ b[W-1];
            acc   <= '0;
            cnt   <= 2'd0;
            state <= M_PROD;
          end
        end
        M_PROD: begin
          prod <= ah * bh;
          psh  <= cnt;
          if (cnt != 2'd0) acc <= acc_sum;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) state <= M_LAST;
        end
        M_LAST: begin
          acc   <= acc_sum;
          state <= M_RND;
        end
        M_RND: begin
          res   <= neg ? -mag_r : mag_r;
          ov    <= big;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/m4inv_div.sv =====
// Restoring divider, one quotient bit per cycle: (n << FRAC) / d, rounded
// half away from zero, symmetric saturation. Depends on m4inv_pkg.
module m4inv_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [m4inv_pkg::WIDE_W-1:0]   n,
  input  logic signed [m4inv_pkg::WIDE_W-1:0]   d,
  output logic                                  done,
  output logic signed [m4inv_pkg::WIDE_W-1:0]   res,
  output logic                                  ov
);

  localparam int W    = m4inv_pkg::WIDE_W;
  localparam int NQ_W = W + m4inv_pkg::FRAC_W;
  localparam int CW   = $clog2(NQ_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND} dstate_t;

  dstate_t       state;
  logic [CW-1:0] cnt;
  logic [NQ_W-1:0] nq;
  logic [W-1:0]  ud;
  logic [W:0]    rem;
  logic [W:0]    rem_s;
  logic          ge;
  logic          neg;
  logic          big;
  logic          rnd;
  logic [W-1:0]  qv;
  logic [W-1:0]  magv;

  always_comb begin
    rem_s = {rem[W-1:0], nq[NQ_W-1]};
    ge    = rem_s >= {1'b0, ud};
    big   = |nq[NQ_W-1:W-1];
    rnd   = {rem[W-1:0], 1'b0} >= {1'b0, ud};
    qv    = {1'b0, nq[W-2:0]} + W'(rnd);
    magv  = (big || qv[W-1]) ? m4inv_pkg::WIDE_MAX : qv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            nq    <= {(n[W-1] ? (~n + W'(1)) : n), {m4inv_pkg::FRAC_W{1'b0}}};
            ud    <= d[W-1] ? (~d + W'(1)) : d;
            neg   <= n[W-1] ^ d[W-1];
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem   <= ge ? (rem_s - {1'b0, ud}) : rem_s;
          nq    <= {nq[NQ_W-2:0], ge};
          cnt   <= cnt + CW'(1);
          if (cnt == CW'(NQ_W - 1)) state <= D_RND;
        end
        D_RND: begin
          res   <= neg ? -magv : magv;
          ov    <= big | qv[W-1];
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/m4inv_dp.sv =====
// Datapath: element and cofactor stores, minor registers, multiply-accumulate,
// determinant, divider and output register. Depends on m4inv_pkg, m4inv_ram,
// m4inv_mul and m4inv_div.
module m4inv_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  m4inv_pkg::cmd_t                          cmd,
  output m4inv_pkg::status_t                       st,
  input  logic signed [m4inv_pkg::DATA_W-1:0]      element_value,
  output logic signed [m4inv_pkg::DATA_W-1:0]      result_value,
  output logic [m4inv_pkg::IDX_W-1:0]              result_index,
  output logic signed [m4inv_pkg::DATA_W-1:0]      determinant_value,
  output logic                                     singular_flag,
  output logic                                     overflow_flag
);

  localparam int W  = m4inv_pkg::WIDE_W;
  localparam int DW = m4inv_pkg::DATA_W;

  logic [DW-1:0]          mat_rdata;
  logic [W-1:0]           cof_rdata;
  logic signed [W-1:0]    mat_ext;
  logic signed [W-1:0]    mreg [m4inv_pkg::MREG_N];
  logic signed [W-1:0]    t0, t1, t2, acc, cof, det;
  logic                   cur_ov;
  logic                   dov;
  logic [m4inv_pkg::NELEM-1:0] cov;

  logic signed [W-1:0]    mul_b;
  logic signed [W-1:0]    mres;
  logic                   mov;
  logic                   mdone;
  logic signed [W-1:0]    dres;
  logic                   dovf;
  logic                   ddone;

  logic signed [W-1:0]    base;
  logic signed [W:0]      s65;
  logic signed [W-1:0]    sum;
  logic                   aov;
  logic signed [W:0]      wmax65;

  logic [DW:0]            det_sat;
  logic [DW:0]            cof_sat;
  logic [DW:0]            div_sat;

  m4inv_ram #(.WIDTH(DW), .DEPTH(m4inv_pkg::NELEM)) u_mat_ram (
    .clk   (clk),
    .we    (cmd.mat_we),
    .waddr (cmd.mat_waddr),
    .wdata (element_value),
    .raddr (cmd.mat_raddr),
    .rdata (mat_rdata)
  );

  m4inv_ram #(.WIDTH(W), .DEPTH(m4inv_pkg::NELEM)) u_cof_ram (
    .clk   (clk),
    .we    (cmd.cof_we),
    .waddr (cmd.cof_waddr),
    .wdata (cof),
    .raddr (cmd.cof_raddr),
    .rdata (cof_rdata)
  );

  m4inv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mreg[cmd.uop.xsel]),
    .b     (mul_b),
    .done  (mdone),
    .res   (mres),
    .ov    (mov)
  );

  m4inv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (cof_rdata),
    .d     (det),
    .done  (ddone),
    .res   (dres),
    .ov    (dovf)
  );

  assign mat_ext = {{(W-DW){mat_rdata[DW-1]}}, mat_rdata};
  assign st      = '{mul_done: mdone, div_done: ddone, sing: singular_flag};

  always_comb begin
    unique case (cmd.uop.ysel)
      m4inv_pkg::Y_M6:  mul_b = mreg[6];
      m4inv_pkg::Y_M7:  mul_b = mreg[7];
      m4inv_pkg::Y_M8:  mul_b = mreg[8];
      m4inv_pkg::Y_T0:  mul_b = t0;
      m4inv_pkg::Y_T1:  mul_b = t1;
      m4inv_pkg::Y_T2:  mul_b = t2;
      m4inv_pkg::Y_COF: mul_b = cof;
      default:          mul_b = cof;
    endcase

    // saturating accumulate onto acc, onto det for the expansion term, or onto zero for a clear
    if (cmd.uop.aop == m4inv_pkg::AOP_CLR)        base = '0;
    else if (cmd.uop.dest == m4inv_pkg::D_DET)    base = det;
    else                                          base = acc;
    wmax65 = {1'b0, m4inv_pkg::WIDE_MAX};
    if (cmd.uop.aop == m4inv_pkg::AOP_SUB) s65 = {base[W-1], base} - {mres[W-1], mres};
    else                                   s65 = {base[W-1], base} + {mres[W-1], mres};
    if (s65 > wmax65) begin
      sum = m4inv_pkg::WIDE_MAX;
      aov = 1'b1;
    end else if (s65 < -wmax65) begin
      sum = -m4inv_pkg::WIDE_MAX;
      aov = 1'b1;
    end else begin
      sum = s65[W-1:0];
      aov = 1'b0;
    end

    det_sat = m4inv_pkg::sat_data(det);
    cof_sat = m4inv_pkg::sat_data(cof_rdata);
    div_sat = m4inv_pkg::sat_data(dres);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) mreg[cmd.ld_idx] <= mat_ext;
    if (cmd.ov_clr) cur_ov <= 1'b0;
    if (cmd.run_clr) begin
      det <= '0;
      dov <= 1'b0;
    end
    if (cmd.apply) begin
      if (cmd.uop.dest == m4inv_pkg::D_DET) begin
        det <= sum;
        dov <= dov | cur_ov | mov | aov;
      end else begin
        acc    <= sum;
        cur_ov <= cur_ov | mov | aov;
        unique case (cmd.uop.dest)
          m4inv_pkg::D_T0:  t0  <= sum;
          m4inv_pkg::D_T1:  t1  <= sum;
          m4inv_pkg::D_T2:  t2  <= sum;
          m4inv_pkg::D_COF: cof <= cmd.neg ? -sum : sum;
          default: ;
        endcase
      end
    end
    if (cmd.cof_we) cov[cmd.cof_waddr] <= cur_ov;
    if (cmd.fin) begin
      determinant_value <= det_sat[DW-1:0];
      dov               <= dov | det_sat[DW];
      singular_flag     <= (det == '0);
    end
    if (cmd.out_load) begin
      result_index <= cmd.out_idx;
      unique case (cmd.out_src)
        m4inv_pkg::SRC_MAT: begin
          result_value  <= mat_rdata;
          overflow_flag <= dov;
        end
        m4inv_pkg::SRC_COF: begin
          result_value  <= cof_sat[DW-1:0];
          overflow_flag <= dov | cov[cmd.cof_raddr] | cof_sat[DW];
        end
        m4inv_pkg::SRC_DIV: begin
          result_value  <= div_sat[DW-1:0];
          overflow_flag <= dov | cov[cmd.cof_raddr] | dovf | div_sat[DW];
        end
        default: begin
          result_value  <= mat_rdata;
          overflow_flag <= dov;
        end
      endcase
    end
  end

endmodule

// ===== rtl/m4inv_ctrl.sv =====
// Controller: load counting, cofactor/determinant sequencing and result
// emission. Drives the datapath through cmd_t. Depends on m4inv_pkg.
module m4inv_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 mode,
  input  logic                       element_valid,
  output logic                       element_ready,
  output logic                       result_valid,
  input  logic                       result_ready,
  output m4inv_pkg::cmd_t            cmd,
  input  m4inv_pkg::status_t         st
);

  typedef enum logic [3:0] {
    S_LOAD, S_MINOR, S_UOP, S_MULW, S_COFW, S_FIN, S_RD, S_GET, S_DIVW, S_OUT
  } state_t;

  state_t     state;
  logic [3:0] lcnt;
  logic [3:0] cidx;
  logic [3:0] k;
  logic [3:0] u;
  logic [3:0] p;
  logic [1:0] mode_run;
  logic [3:0] tp;
  logic       inv_go;

  assign element_ready = (state == S_LOAD);
  assign result_valid  = (state == S_OUT);
  assign tp            = {p[1:0], p[3:2]};
  assign inv_go        = (mode_run == m4inv_pkg::MODE_INV) && !st.sing;

  always_comb begin
    cmd           = '0;
    cmd.uop       = m4inv_pkg::uop_dec(u);
    cmd.out_src   = m4inv_pkg::SRC_MAT;
    cmd.mat_waddr = lcnt;
    cmd.mat_we    = element_valid && (state == S_LOAD);
    cmd.run_clr   = cmd.mat_we && (lcnt == m4inv_pkg::LAST_IDX);
    cmd.cof_waddr = cidx;
    cmd.neg       = cidx[0] ^ cidx[2];
    cmd.out_idx   = p;
    cmd.cof_raddr = (mode_run == m4inv_pkg::MODE_INV || mode_run == m4inv_pkg::MODE_ADJ)
                    ? tp : p;
    cmd.mat_raddr = p;
    unique case (state)
      S_MINOR: begin
        cmd.mat_raddr = m4inv_pkg::minor_addr(cidx[1:0], cidx[3:2], k);
        cmd.ld_en     = (k != 4'd0);
        cmd.ld_idx    = k - 4'd1;
        cmd.ov_clr    = (k == 4'd0);
      end
      S_UOP:  cmd.mul_start = 1'b1;
      S_MULW: cmd.apply     = st.mul_done;
      S_COFW: cmd.cof_we    = 1'b1;
      S_FIN:  cmd.fin       = 1'b1;
      S_GET: begin
        cmd.div_start = inv_go;
        cmd.out_load  = !inv_go;
        cmd.out_src   = (mode_run == m4inv_pkg::MODE_INV) ? m4inv_pkg::SRC_MAT
                                                          : m4inv_pkg::SRC_COF;
      end
      S_DIVW: begin
        cmd.out_load = st.div_done;
        cmd.out_src  = m4inv_pkg::SRC_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      lcnt     <= 4'd0;
      cidx     <= 4'd0;
      k        <= 4'd0;
      u        <= 4'd0;
      p        <= 4'd0;
      mode_run <= m4inv_pkg::MODE_INV;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (element_valid) begin
            lcnt <= lcnt + 4'd1;
            if (lcnt == m4inv_pkg::LAST_IDX) begin
              mode_run <= mode;
              cidx     <= 4'd0;
              k        <= 4'd0;
              state    <= S_MINOR;
            end
          end
        end
        S_MINOR: begin
          if (k == m4inv_pkg::MINOR_END) begin
            u     <= 4'd0;
            state <= S_UOP;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_UOP: state <= S_MULW;
        S_MULW: begin
          if (st.mul_done) begin
            if (u == m4inv_pkg::UOP_COF) begin
              state <= S_COFW;
            end else if (u == m4inv_pkg::UOP_DET) begin
              cidx  <= cidx + 4'd1;
              k     <= 4'd0;
              state <= (cidx == m4inv_pkg::LAST_IDX) ? S_FIN : S_MINOR;
            end else begin
              u     <= u + 4'd1;
              state <= S_UOP;
            end
          end
        end
        S_COFW: begin
          // row-0 cofactors feed the determinant expansion in column order
          if (cidx[1:0] == 2'd0) begin
            u     <= m4inv_pkg::UOP_DET;
            state <= S_UOP;
          end else if (cidx == m4inv_pkg::LAST_IDX) begin
            state <= S_FIN;
          end else begin
            cidx  <= cidx + 4'd1;
            k     <= 4'd0;
            state <= S_MINOR;
          end
        end
        S_FIN: begin
          p     <= 4'd0;
          state <= S_RD;
        end
        S_RD:  state <= S_GET;
        S_GET: state <= inv_go ? S_DIVW : S_OUT;
        S_DIVW: begin
          if (st.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            p     <= p + 4'd1;
            state <= (p == m4inv_pkg::LAST_IDX) ? S_LOAD : S_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/mat4_inverse_adjugate.sv =====
// 4x4 Q16.16 matrix inverse / adjugate / cofactor unit: 16 element transfers in,
// one per cycle while element_valid is high, then 16 cofactors and the determinant are formed
// (per cofactor: nine minor elements and e0 loaded from the store, then nine
// sequential multiplies, plus one for the determinant term on row 0). Results leave
// one at a time; for a nonsingular inverse the one-bit-per-cycle divider sets the pace.
// Synchronous reset clears control state and result_mode; the stores are not cleared.
`include "mat4_inverse_adjugate_macros.svh"
module mat4_inverse_adjugate (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [m4inv_pkg::CFG_W-1:0]           pwdata,
  output logic [m4inv_pkg::CFG_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  element_valid,
  output logic                                  element_ready,
  input  logic signed [m4inv_pkg::DATA_W-1:0]   element_value,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [m4inv_pkg::DATA_W-1:0]   result_value,
  output logic [m4inv_pkg::IDX_W-1:0]           result_index,
  output logic signed [m4inv_pkg::DATA_W-1:0]   determinant_value,
  output logic                                  singular_flag,
  output logic                                  overflow_flag,
  output logic                                  last_flag
);

  logic [1:0]          result_mode;
  m4inv_pkg::cmd_t     cmd;
  m4inv_pkg::status_t  st;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == m4inv_pkg::REG_MODE)
                     ? {{(m4inv_pkg::CFG_W-2){1'b0}}, result_mode} : '0;
  assign last_flag = (result_index == m4inv_pkg::LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_mode <= m4inv_pkg::MODE_INV;
    end else if (psel && penable && pwrite && pready && paddr[2] == m4inv_pkg::REG_MODE) begin
      result_mode <= pwdata[1:0];
    end
  end

  m4inv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .mode          (result_mode),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .cmd           (cmd),
    .st            (st)
  );

  m4inv_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .element_value     (element_value),
    .result_value      (result_value),
    .result_index      (result_index),
    .determinant_value (determinant_value),
    .singular_flag     (singular_flag),
    .overflow_flag     (overflow_flag)
  );

  `M4INV_ASSERT_IMP(a_no_overlap, element_ready, !result_valid)
  `M4INV_ASSERT_NXT(a_last_reload, result_valid && result_ready && last_flag, element_ready)
  `M4INV_ASSERT_NXT(a_emit_gap, result_valid && result_ready && !last_flag, !result_valid)
  `M4INV_ASSERT_IMP(a_sing_det, result_valid && singular_flag, determinant_value == '0)

endmodule
